// ----- rtl/motion_overlap_probability_unit_macros.svh -----
// ----------------------------------------------------------------------------
// motion overlap probability unit: assertion macros
// property wrappers clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MOTION_OVERLAP_PROBABILITY_UNIT_MACROS_SVH
`define MOTION_OVERLAP_PROBABILITY_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every edge out of reset
`define MOPU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mopu check failed");
// condition in one cycle implies a property in the next
`define MOPU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mopu check failed");
`else
`define MOPU_ASSERT(lbl, prop)
`define MOPU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- rtl/mop_pkg.sv -----
// ----------------------------------------------------------------------------
// mop_pkg
// types, constants and helpers shared by the motion overlap probability unit
// ----------------------------------------------------------------------------
package mop_pkg;

  localparam int FracBits  = 16;
  localparam int NBits     = FracBits + 1;
  localparam int CellW     = 31;
  localparam int ThrW      = 16;
  localparam int ProdW     = 64;
  localparam int NumNW     = 33;
  localparam int UW        = FracBits + 1;
  localparam int LinW      = FracBits + 4;
  localparam int ProdCW    = FracBits + LinW + 1;
  localparam int ValW      = LinW + 1;

  // pipeline stage map
  localparam int StgDiv0   = 2;
  localparam int StgNEnd   = StgDiv0 + NBits - 1;
  localparam int StgCEnd   = StgNEnd + FracBits;
  localparam int StgSq     = StgCEnd + 1;
  localparam int StgMul    = StgCEnd + 2;
  localparam int StgOut    = StgCEnd + 3;
  localparam int NumStages = StgOut + 1;

  localparam logic [FracBits:0] OneF = {1'b1, {FracBits{1'b0}}};

  localparam logic [0:0]       RegCellSize = 1'b0;
  localparam logic [0:0]       RegStillThr = 1'b1;
  localparam logic [CellW-1:0] CellSizeRst = 31'd65536;
  localparam logic [ThrW-1:0]  StillThrRst = 16'd1;

  typedef struct packed {
    logic signed [31:0] obj_dist;
    logic signed [31:0] bot_dist;
    logic [30:0]        obj_speed;
    logic [30:0]        bot_speed;
  } in_item_t;

  typedef struct packed {
    logic [16:0] prob;
    logic        degenerate;
  } out_item_t;

  typedef enum logic [2:0] {
    CaseMiss,
    CaseLeft,
    CaseBothLeft,
    CaseMiddle,
    CaseBothRight,
    CaseRight
  } span_case_e;

  typedef struct packed {
    logic             still;
    logic             still_hit;
    logic             degen;
    logic             big;
    logic             neg_u;
    logic             neg_w;
    logic [ProdW-1:0] q;
    logic [ProdW-1:0] m1;
    logic [ProdW-1:0] m2;
    logic [NumNW-1:0] num_n;
  } front_t;

  typedef struct packed {
    logic       still;
    logic       still_hit;
    logic       degen;
    logic       big;
    logic       neg_u;
    logic       neg_w;
    span_case_e span;
  } side_t;

  // one restoring step of a fraction division: {quotient bit, new remainder}
  function automatic logic [ProdW:0] frac_step(input logic [ProdW-1:0] rem,
                                               input logic [ProdW-1:0] den);
    logic [ProdW:0] r2;
    logic [ProdW:0] dd;
    r2 = {rem, 1'b0};
    dd = {1'b0, den};
    if (r2 >= dd) begin
      frac_step = {1'b1, ProdW'(r2 - dd)};
    end else begin
      frac_step = {1'b0, r2[ProdW-1:0]};
    end
  endfunction

endpackage

// ----- rtl/mop_front.sv -----
// ----------------------------------------------------------------------------
// mop_front
// input stage and product stage: magnitudes, bound numerators and denominator
// ----------------------------------------------------------------------------
module mop_front (
  input  logic                            clk_i,
  input  logic [mop_pkg::NumStages-1:0]   en_i,
  input  mop_pkg::in_item_t               in_data_i,
  input  logic [mop_pkg::CellW-1:0]       cell_size_i,
  input  logic [mop_pkg::ThrW-1:0]        still_thr_i,
  output mop_pkg::front_t                 front_o
);
  import mop_pkg::*;

  logic [31:0]        ad_d, ad_q, obj_mag;
  logic [30:0]        vo_q, vr_q;
  logic signed [33:0] a2_d, a2_q, b2_d, b2_q;
  logic [NumNW-1:0]   numn_d, numn_q;
  logic               still_d, still_q, hit_d, hit_q, degen_d, degen_q, big_d, big_q;
  logic [32:0]        ma, mb;
  logic [62:0]        qh;
  front_t             front_d, front_q;

  always_comb begin
    ad_d    = in_data_i.bot_dist[31] ? $unsigned(-in_data_i.bot_dist)
                                     : $unsigned(in_data_i.bot_dist);
    obj_mag = in_data_i.obj_dist[31] ? $unsigned(-in_data_i.obj_dist)
                                     : $unsigned(in_data_i.obj_dist);
    a2_d    = $signed({in_data_i.obj_dist[31], in_data_i.obj_dist, 1'b0})
            - $signed({3'b000, cell_size_i});
    b2_d    = $signed({in_data_i.obj_dist[31], in_data_i.obj_dist, 1'b0})
            + $signed({3'b000, cell_size_i});
    numn_d  = {1'b0, ad_d} + {2'b00, cell_size_i} - 33'd1;
    // more than 2^F cells away: correction saturates
    big_d   = {{(CellW+FracBits-32){1'b0}}, ad_d} > {cell_size_i, {FracBits{1'b0}}};
    still_d = in_data_i.obj_speed < {{(CellW-ThrW){1'b0}}, still_thr_i};
    hit_d   = obj_mag < {1'b0, cell_size_i};
    degen_d = (ad_d == '0) || (in_data_i.bot_speed == '0)
           || (in_data_i.obj_speed == '0) || (cell_size_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ad_q    <= ad_d;
      vo_q    <= in_data_i.obj_speed;
      vr_q    <= in_data_i.bot_speed;
      a2_q    <= a2_d;
      b2_q    <= b2_d;
      numn_q  <= numn_d;
      still_q <= still_d;
      hit_q   <= hit_d;
      degen_q <= degen_d;
      big_q   <= big_d;
    end
  end

  always_comb begin
    ma = a2_q[33] ? 33'(-a2_q) : a2_q[32:0];
    mb = b2_q[33] ? 33'(-b2_q) : b2_q[32:0];
    qh = ad_q * vo_q;
    front_d.still     = still_q;
    front_d.still_hit = hit_q;
    front_d.degen     = degen_q;
    front_d.big       = big_q;
    front_d.neg_u     = a2_q[33];
    front_d.neg_w     = b2_q[33];
    front_d.q         = {qh, 1'b0};
    front_d.m1        = ma * vr_q;
    front_d.m2        = mb * vr_q;
    front_d.num_n     = numn_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ----- rtl/mop_divide.sv -----
// ----------------------------------------------------------------------------
// mop_divide
// bit-per-stage dividers: cell count, correction factor and the two bounds
// ----------------------------------------------------------------------------
module mop_divide (
  input  logic                            clk_i,
  input  logic [mop_pkg::NumStages-1:0]   en_i,
  input  logic [mop_pkg::CellW-1:0]       cell_size_i,
  input  mop_pkg::front_t                 front_i,
  output logic [mop_pkg::FracBits-1:0]    c_o,
  output logic [mop_pkg::UW-1:0]          u_mag_o,
  output logic [mop_pkg::UW-1:0]          w_mag_o,
  output mop_pkg::side_t                  side_o
);
  import mop_pkg::*;

  localparam int StgRide = StgDiv0 + FracBits;

  side_t            side_d;
  side_t            side_q   [StgDiv0:StgCEnd];
  logic             lt1, lt2, gt1;

  logic [NumNW-1:0] nrem_q   [NBits];
  logic [NBits-1:0] nquo_q   [NBits];

  logic [ProdW-1:0] urem_q   [FracBits];
  logic [ProdW-1:0] wrem_q   [FracBits];
  logic [ProdW-1:0] qden_q   [FracBits];
  logic [FracBits-1:0] uquo_q [FracBits];
  logic [FracBits-1:0] wquo_q [FracBits];
  logic             usat_q   [FracBits];
  logic             wsat_q   [FracBits];

  logic [NBits-1:0] crem_q   [FracBits];
  logic [NBits-1:0] cden_q   [FracBits];
  logic [FracBits-1:0] cquo_q [FracBits];

  logic [UW-1:0]    umag_q   [StgRide:StgCEnd];
  logic [UW-1:0]    wmag_q   [StgRide:StgCEnd];

  // overlap case from exact compares of the numerators against the denominator
  always_comb begin
    gt1 = front_i.m1 > front_i.q;
    lt1 = front_i.m1 < front_i.q;
    lt2 = front_i.m2 < front_i.q;
    side_d.still     = front_i.still;
    side_d.still_hit = front_i.still_hit;
    side_d.degen     = front_i.degen;
    side_d.big       = front_i.big;
    side_d.neg_u     = front_i.neg_u;
    side_d.neg_w     = front_i.neg_w;
    if (front_i.neg_u && gt1) begin
      side_d.span = (front_i.neg_w && lt2 && (front_i.m2 != '0)) ? CaseLeft : CaseMiss;
    end else if (front_i.neg_u) begin
      if (front_i.neg_w) begin
        side_d.span = CaseBothLeft;
      end else if (lt2) begin
        side_d.span = CaseMiddle;
      end else begin
        side_d.span = CaseMiss;
      end
    end else if (lt1) begin
      side_d.span = lt2 ? CaseBothRight : CaseRight;
    end else begin
      side_d.span = CaseMiss;
    end
  end

  for (genvar k = StgDiv0; k <= StgCEnd; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        if (k == StgDiv0) begin
          side_q[k] <= side_d;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // cell count n = ceil(|bot_dist| / cell_size), msb first
  for (genvar j = 0; j < NBits; j++) begin : g_ndiv
    localparam int Bit = NBits - 1 - j;
    logic [NumNW-1:0]       rem_p, rem_d;
    logic [NBits-1:0]       quo_p, quo_d;
    logic [CellW+NBits-1:0] dsh, ext;
    always_comb begin
      if (j == 0) begin
        rem_p = front_i.num_n;
        quo_p = '0;
      end else begin
        rem_p = nrem_q[j-1];
        quo_p = nquo_q[j-1];
      end
      dsh   = {{NBits{1'b0}}, cell_size_i} << Bit;
      ext   = {{(CellW+NBits-NumNW){1'b0}}, rem_p};
      rem_d = rem_p;
      quo_d = quo_p;
      if (ext >= dsh) begin
        rem_d      = NumNW'(ext - dsh);
        quo_d[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[StgDiv0+j]) begin
        nrem_q[j] <= rem_d;
        nquo_q[j] <= quo_d;
      end
    end
  end

  // correction (n-1)/n, one fraction bit per stage
  for (genvar j = 0; j < FracBits; j++) begin : g_cdiv
    logic [NBits-1:0]    rem_p, den_p, rem_d;
    logic [FracBits-1:0] quo_p, quo_d;
    logic [NBits:0]      r2;
    always_comb begin
      if (j == 0) begin
        den_p = nquo_q[NBits-1];
        rem_p = nquo_q[NBits-1] - NBits'(1);
        quo_p = '0;
      end else begin
        den_p = cden_q[j-1];
        rem_p = crem_q[j-1];
        quo_p = cquo_q[j-1];
      end
      r2 = {rem_p, 1'b0};
      if (r2 >= {1'b0, den_p}) begin
        rem_d = NBits'(r2 - {1'b0, den_p});
        quo_d = {quo_p[FracBits-2:0], 1'b1};
      end else begin
        rem_d = r2[NBits-1:0];
        quo_d = {quo_p[FracBits-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[StgNEnd+1+j]) begin
        crem_q[j] <= rem_d;
        cden_q[j] <= den_p;
        cquo_q[j] <= quo_d;
      end
    end
  end

  // normalised bounds |u| and |w|, saturating at one
  for (genvar j = 0; j < FracBits; j++) begin : g_uwdiv
    logic [ProdW-1:0]    ur_p, wr_p, den_p;
    logic [FracBits-1:0] uq_p, wq_p;
    logic                us_p, ws_p;
    logic [ProdW:0]      ustep, wstep;
    always_comb begin
      if (j == 0) begin
        ur_p  = front_i.m1;
        wr_p  = front_i.m2;
        den_p = front_i.q;
        uq_p  = '0;
        wq_p  = '0;
        us_p  = !lt1;
        ws_p  = !lt2;
      end else begin
        ur_p  = urem_q[j-1];
        wr_p  = wrem_q[j-1];
        den_p = qden_q[j-1];
        uq_p  = uquo_q[j-1];
        wq_p  = wquo_q[j-1];
        us_p  = usat_q[j-1];
        ws_p  = wsat_q[j-1];
      end
      ustep = frac_step(ur_p, den_p);
      wstep = frac_step(wr_p, den_p);
    end
    always_ff @(posedge clk_i) begin
      if (en_i[StgDiv0+j]) begin
        urem_q[j] <= ustep[ProdW-1:0];
        wrem_q[j] <= wstep[ProdW-1:0];
        qden_q[j] <= den_p;
        uquo_q[j] <= {uq_p[FracBits-2:0], ustep[ProdW]};
        wquo_q[j] <= {wq_p[FracBits-2:0], wstep[ProdW]};
        usat_q[j] <= us_p;
        wsat_q[j] <= ws_p;
      end
    end
  end

  for (genvar k = StgRide; k <= StgCEnd; k++) begin : g_ride
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        if (k == StgRide) begin
          umag_q[k] <= usat_q[FracBits-1] ? OneF : {1'b0, uquo_q[FracBits-1]};
          wmag_q[k] <= wsat_q[FracBits-1] ? OneF : {1'b0, wquo_q[FracBits-1]};
        end else begin
          umag_q[k] <= umag_q[k-1];
          wmag_q[k] <= wmag_q[k-1];
        end
      end
    end
  end

  assign c_o     = cquo_q[FracBits-1];
  assign u_mag_o = umag_q[StgCEnd];
  assign w_mag_o = wmag_q[StgCEnd];
  assign side_o  = side_q[StgCEnd];

endmodule

// ----- rtl/mop_combine.sv -----
// ----------------------------------------------------------------------------
// mop_combine
// squares, correction product, case sum, clamp and the output register
// ----------------------------------------------------------------------------
module mop_combine (
  input  logic                            clk_i,
  input  logic [mop_pkg::NumStages-1:0]   en_i,
  input  logic [mop_pkg::FracBits-1:0]    c_i,
  input  logic [mop_pkg::UW-1:0]          u_mag_i,
  input  logic [mop_pkg::UW-1:0]          w_mag_i,
  input  mop_pkg::side_t                  side_i,
  output mop_pkg::out_item_t              out_data_o
);
  import mop_pkg::*;

  logic [2*UW-1:0]           usq, wsq;
  logic signed [LinW-1:0]    us, ws, one_s, lin_d, lin_q, lin2_q, quad;
  logic [UW-1:0]             squ_q, sqw_q;
  logic [FracBits-1:0]       cf_q;
  span_case_e                span_q;
  logic                      plus_d, plus_q, plus2_q, hit_q;
  logic                      still_q, still2_q, shit_q, shit2_q, degen_q, degen2_q;
  logic signed [ProdCW-1:0]  prod_d, prod_q;
  logic signed [ValW-1:0]    term, val;
  out_item_t                 out_d, out_q;

  // stage one: squares and linear term
  always_comb begin
    one_s = LinW'({1'b0, OneF});
    us    = side_i.neg_u ? -$signed(LinW'(u_mag_i)) : $signed(LinW'(u_mag_i));
    ws    = side_i.neg_w ? -$signed(LinW'(w_mag_i)) : $signed(LinW'(w_mag_i));
    usq   = u_mag_i * u_mag_i;
    wsq   = w_mag_i * w_mag_i;
    plus_d = (side_i.span == CaseLeft) || (side_i.span == CaseBothLeft);
    case (side_i.span)
      CaseLeft:      lin_d = ws + one_s;
      CaseBothLeft,
      CaseMiddle,
      CaseBothRight: lin_d = ws - us;
      CaseRight:     lin_d = one_s - us;
      default:       lin_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgSq]) begin
      squ_q   <= usq[FracBits+UW-1:FracBits];
      sqw_q   <= wsq[FracBits+UW-1:FracBits];
      cf_q    <= side_i.big ? '1 : c_i;
      lin_q   <= lin_d;
      span_q  <= side_i.span;
      plus_q  <= plus_d;
      still_q <= side_i.still;
      shit_q  <= side_i.still_hit;
      degen_q <= side_i.degen;
    end
  end

  // stage two: quadratic term times correction
  always_comb begin
    case (span_q)
      CaseLeft:      quad = $signed(LinW'(sqw_q)) - one_s;
      CaseBothLeft,
      CaseBothRight: quad = $signed(LinW'(sqw_q)) - $signed(LinW'(squ_q));
      CaseMiddle:    quad = $signed(LinW'(sqw_q)) + $signed(LinW'(squ_q));
      CaseRight:     quad = one_s - $signed(LinW'(squ_q));
      default:       quad = '0;
    endcase
    prod_d = $signed({1'b0, cf_q}) * quad;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgMul]) begin
      prod_q   <= prod_d;
      lin2_q   <= lin_q;
      plus2_q  <= plus_q;
      hit_q    <= span_q != CaseMiss;
      still2_q <= still_q;
      shit2_q  <= shit_q;
      degen2_q <= degen_q;
    end
  end

  // stage three: floor shift, sum, clamp, special cases
  always_comb begin
    term = ValW'(prod_q >>> (FracBits + 1));
    val  = plus2_q ? (ValW'(lin2_q) + term) : (ValW'(lin2_q) - term);
    if (!hit_q || val < 0) begin
      val = '0;
    end else if (val > $signed(ValW'({1'b0, OneF}))) begin
      val = ValW'({1'b0, OneF});
    end
    out_d.degenerate = 1'b0;
    if (still2_q) begin
      out_d.prob = shit2_q ? OneF : '0;
    end else if (degen2_q) begin
      out_d.prob       = '0;
      out_d.degenerate = 1'b1;
    end else begin
      out_d.prob = val[FracBits:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgOut]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/motion_overlap_probability_unit.sv -----
// ----------------------------------------------------------------------------
// motion_overlap_probability_unit
// probability that a moving object sits in a grid cell when the robot arrives
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        sink       in_valid_i / in_stall_o   in_data_i  (obj/bot dist, speeds)
// out       source     out_valid_o / out_stall_i out_data_o (prob, degenerate)
// cfg       apb slave  psel/penable/pwrite       paddr, pwdata, prdata
//
// one transfer per cycle in while in_stall_o is low
// the pipeline depth is set by the 17-step cell count division followed by the
// 16-step correction division, each a compare-subtract stage
// reset clears the stage valid bits and loads the register defaults
// a stalled output lets bubbles further up close, so input keeps flowing
// until every stage holds an item
// ----------------------------------------------------------------------------
`include "motion_overlap_probability_unit_macros.svh"

module motion_overlap_probability_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mop_pkg::in_item_t      in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mop_pkg::out_item_t     out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import mop_pkg::*;

  logic [CellW-1:0]     cell_size_q;
  logic [ThrW-1:0]      still_thr_q;
  logic [NumStages-1:0] valid_q, en;
  logic                 cfg_wr;
  front_t               front;
  side_t                side;
  logic [FracBits-1:0]  corr;
  logic [UW-1:0]        u_mag, w_mag;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CellSizeRst;
      still_thr_q <= StillThrRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegCellSize: cell_size_q <= pwdata[CellW-1:0];
        RegStillThr: still_thr_q <= pwdata[ThrW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegCellSize: prdata = {1'b0, cell_size_q};
      RegStillThr: prdata = {16'b0, still_thr_q};
      default:     prdata = '0;
    endcase
  end

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStages-1];

  mop_front u_front (
    .clk_i       (clk_i),
    .en_i        (en),
    .in_data_i   (in_data_i),
    .cell_size_i (cell_size_q),
    .still_thr_i (still_thr_q),
    .front_o     (front)
  );

  mop_divide u_divide (
    .clk_i       (clk_i),
    .en_i        (en),
    .cell_size_i (cell_size_q),
    .front_i     (front),
    .c_o         (corr),
    .u_mag_o     (u_mag),
    .w_mag_o     (w_mag),
    .side_o      (side)
  );

  mop_combine u_combine (
    .clk_i       (clk_i),
    .en_i        (en),
    .c_i         (corr),
    .u_mag_i     (u_mag),
    .w_mag_i     (w_mag),
    .side_i      (side),
    .out_data_o  (out_data_o)
  );

  `MOPU_ASSERT(a_degen_zero, out_valid_o && out_data_o.degenerate |-> out_data_o.prob == '0)
  `MOPU_ASSERT(a_prob_range, out_valid_o |-> out_data_o.prob <= OneF)
  `MOPU_ASSERT_NEXT(a_take_in, in_valid_i && !in_stall_o, valid_q[0])
  `MOPU_ASSERT_NEXT(a_cfg_cell, cfg_wr && (paddr[2] == RegCellSize), cell_size_q == $past(pwdata[CellW-1:0]))

endmodule
